// ----- rtl/core/twrm_pkg.sv -----
`timescale 1ns / 1ps

package twrm_pkg;

    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 8;
    localparam int FRAME_BITS = ADDR_BITS + 1;
    localparam int RX_BITS    = DATA_BITS + 1;
    localparam int SHIFT_W    = (FRAME_BITS > RX_BITS) ? FRAME_BITS : RX_BITS;
    localparam int CNT_W      = $clog2(SHIFT_W + 1);

    localparam int REQ_W  = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_CODE_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CODE_WRITE = 2'd2;

    typedef enum logic [1:0] {
        REQ_TICK,
        REQ_READ,
        REQ_WRITE
    } t_req;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NACK_REG,
        ST_NACK_DATA
    } t_status;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_STOP_SCLH,
        PH_STOP_SDAH,
        PH_START_SDAL,
        PH_START_SCLL,
        PH_A_SET,
        PH_A_HIGH,
        PH_A_LOW,
        PH_A_TURN,
        PH_A_ACKH,
        PH_A_ACKL,
        PH_R_HIGH,
        PH_R_LOW,
        PH_W_TURN,
        PH_W_SET,
        PH_W_HIGH,
        PH_W_LOW,
        PH_W_TURN_IN,
        PH_W_ACKH,
        PH_W_ACKL
    } t_phase;

    typedef struct packed {
        t_req              req;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdat;
        logic              sda;
    } t_item;

endpackage

// ----- rtl/core/twrm_front.sv -----
`timescale 1ns / 1ps

module twrm_front
    import twrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [ADDR_W-1:0] i_reg_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_sda_in,
    output logic              o_item_valid,
    output t_item             o_item,
    input  logic              i_item_pop
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    t_item              n_item;
    logic               push, pop;

    always_comb begin
        n_item.addr = i_reg_addr;
        n_item.wdat = i_wr_data;
        n_item.sda  = i_sda_in;
        unique case (i_req_type)
            REQ_CODE_READ:  n_item.req = REQ_READ;
            REQ_CODE_WRITE: n_item.req = REQ_WRITE;
            default:        n_item.req = REQ_TICK;
        endcase
    end

    assign o_ready      = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_count != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/twrm_back.sv -----
`timescale 1ns / 1ps

module twrm_back
    import twrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  t_item             i_item,
    output logic              o_item_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_scl,
    output logic              o_sda_out,
    output logic              o_sda_oe,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [DATA_W-1:0] o_rd_data,
    output logic [1:0]        o_status
);

    t_phase               r_phase, n_phase;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [SHIFT_W-1:0]   r_shift, n_shift;
    logic                 r_is_write, n_is_write;
    logic [DATA_BITS-1:0] r_held, n_held;
    logic [DATA_BITS-1:0] r_rd, n_rd;
    t_status              r_status, n_status;
    logic                 r_scl, n_scl;
    logic                 r_sda, n_sda;
    logic                 r_oe, n_oe;
    logic                 r_done, n_done;
    logic                 r_valid;
    logic                 step;
    logic                 last_bit;
    logic                 tx_bit;
    logic                 start_req;

    assign step      = i_item_valid && (!r_valid || i_ready);
    assign o_item_pop = step;
    assign last_bit  = (r_cnt == CNT_W'(1));
    assign tx_bit    = r_shift[r_cnt - 1'b1];
    assign start_req = (i_item.req == REQ_READ) || (i_item.req == REQ_WRITE);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE:       if (start_req) n_phase = PH_STOP_SCLH;
            PH_STOP_SCLH:  n_phase = PH_STOP_SDAH;
            PH_STOP_SDAH:  n_phase = PH_START_SDAL;
            PH_START_SDAL: n_phase = PH_START_SCLL;
            PH_START_SCLL: n_phase = PH_A_SET;
            PH_A_SET:      n_phase = PH_A_HIGH;
            PH_A_HIGH:     n_phase = PH_A_LOW;
            PH_A_LOW:      n_phase = last_bit ? PH_A_TURN : PH_A_SET;
            PH_A_TURN:     n_phase = PH_A_ACKH;
            PH_A_ACKH:     n_phase = PH_A_ACKL;
            PH_A_ACKL: begin
                if (!r_shift[0]) n_phase = PH_IDLE;
                else if (r_is_write) n_phase = PH_W_TURN;
                else n_phase = PH_R_HIGH;
            end
            PH_R_HIGH:     n_phase = PH_R_LOW;
            PH_R_LOW:      n_phase = last_bit ? PH_IDLE : PH_R_HIGH;
            PH_W_TURN:     n_phase = PH_W_SET;
            PH_W_SET:      n_phase = PH_W_HIGH;
            PH_W_HIGH:     n_phase = PH_W_LOW;
            PH_W_LOW:      n_phase = last_bit ? PH_W_TURN_IN : PH_W_SET;
            PH_W_TURN_IN:  n_phase = PH_W_ACKH;
            PH_W_ACKH:     n_phase = PH_W_ACKL;
            PH_W_ACKL:     n_phase = PH_IDLE;
            default:       n_phase = PH_IDLE;
        endcase
    end

    // line levels and datapath
    always_comb begin
        n_cnt      = r_cnt;
        n_shift    = r_shift;
        n_is_write = r_is_write;
        n_held     = r_held;
        n_rd       = r_rd;
        n_status   = r_status;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_oe       = r_oe;
        n_done     = 1'b0;
        unique case (r_phase) inside
            PH_IDLE: begin
                if (start_req) begin
                    n_is_write = (i_item.req == REQ_WRITE);
                    n_held     = i_item.wdat[DATA_BITS-1:0];
                    n_shift    = SHIFT_W'({i_item.addr[ADDR_BITS-1:0],
                                           (i_item.req != REQ_WRITE)});
                    n_oe       = 1'b1;
                    n_scl      = 1'b0;
                    n_sda      = 1'b0;
                end
            end
            PH_STOP_SCLH:  n_scl = 1'b1;
            PH_STOP_SDAH:  n_sda = 1'b1;
            PH_START_SDAL: n_sda = 1'b0;
            PH_START_SCLL: begin
                n_scl = 1'b0;
                n_cnt = CNT_W'(FRAME_BITS);
            end
            PH_A_SET, PH_W_SET: n_sda = tx_bit;
            PH_A_HIGH, PH_W_HIGH: n_scl = 1'b1;
            PH_A_LOW, PH_W_LOW: begin
                n_scl = 1'b0;
                n_cnt = r_cnt - 1'b1;
            end
            PH_A_TURN, PH_W_TURN_IN: n_oe = 1'b0;
            PH_A_ACKH, PH_W_ACKH: begin
                n_scl   = 1'b1;
                n_shift = SHIFT_W'(i_item.sda);
            end
            PH_A_ACKL: begin
                n_scl = 1'b0;
                if (!r_shift[0]) begin
                    n_rd     = '0;
                    n_status = ST_NACK_REG;
                    n_done   = 1'b1;
                end else if (!r_is_write) begin
                    n_cnt   = CNT_W'(RX_BITS);
                    n_shift = '0;
                end
            end
            PH_R_HIGH: begin
                n_scl   = 1'b1;
                n_shift = SHIFT_W'({r_shift[RX_BITS-2:0], i_item.sda});
            end
            PH_R_LOW: begin
                n_scl = 1'b0;
                n_cnt = r_cnt - 1'b1;
                if (last_bit) begin
                    n_done = 1'b1;
                    if (r_shift[0]) begin
                        n_rd     = r_shift[DATA_BITS:1];
                        n_status = ST_OK;
                    end else begin
                        n_rd     = '0;
                        n_status = ST_NACK_DATA;
                    end
                end
            end
            PH_W_TURN: begin
                n_oe    = 1'b1;
                n_shift = SHIFT_W'(r_held);
                n_cnt   = CNT_W'(DATA_BITS);
            end
            PH_W_ACKL: begin
                n_scl    = 1'b0;
                n_rd     = '0;
                n_status = r_shift[0] ? ST_OK : ST_NACK_DATA;
                n_done   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cnt      <= '0;
            r_shift    <= '0;
            r_is_write <= 1'b0;
            r_held     <= '0;
            r_rd       <= '0;
            r_status   <= ST_OK;
            r_scl      <= 1'b0;
            r_sda      <= 1'b0;
            r_oe       <= 1'b0;
            r_done     <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (step) begin
                r_phase    <= n_phase;
                r_cnt      <= n_cnt;
                r_shift    <= n_shift;
                r_is_write <= n_is_write;
                r_held     <= n_held;
                r_rd       <= n_rd;
                r_status   <= n_status;
                r_scl      <= n_scl;
                r_sda      <= n_sda;
                r_oe       <= n_oe;
                r_done     <= n_done;
                r_valid    <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_scl      = r_scl;
    assign o_sda_out  = r_sda;
    assign o_sda_oe   = r_oe;
    assign o_busy_res = (r_phase != PH_IDLE);
    assign o_done_res = r_done;
    assign o_rd_data  = DATA_W'(r_rd);
    assign o_status   = r_status;

endmodule

// ----- rtl/core/two_wire_register_master.sv -----
`timescale 1ns / 1ps
// Channel | Handshake          | Word
// input   | i_valid / o_ready  | i_req_type, i_reg_addr, i_wr_data, i_sda_in
// output  | o_valid / i_ready  | o_scl, o_sda_out, o_sda_oe, o_busy_res,
//         |                    | o_done_res, o_rd_data, o_status
//
// One word in, one word out; one word per cycle sustained while i_ready is high.
// Each word passes the input queue (2 deep), then the line sequencer step,
// which also serves as the output register.
// The sequencer steps only when its output register is free or being taken.
// Synchronous active-low reset empties the queue and idles the sequencer.

module two_wire_register_master
    import twrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [ADDR_W-1:0] i_reg_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_sda_in,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_scl,
    output logic              o_sda_out,
    output logic              o_sda_oe,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [DATA_W-1:0] o_rd_data,
    output logic [1:0]        o_status
);

    t_item item;
    logic  item_valid;
    logic  item_pop;

    twrm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_reg_addr   (i_reg_addr),
        .i_wr_data    (i_wr_data),
        .i_sda_in     (i_sda_in),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    twrm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_scl        (o_scl),
        .o_sda_out    (o_sda_out),
        .o_sda_oe     (o_sda_oe),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_rd_data    (o_rd_data),
        .o_status     (o_status)
    );

endmodule

// ----- rtl/core/twrm_checker.sv -----
`timescale 1ns / 1ps

module twrm_props
    import twrm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_scl,
    input logic              o_sda_oe,
    input logic              o_busy_res,
    input logic              o_done_res,
    input logic [DATA_W-1:0] o_rd_data,
    input logic [1:0]        o_status
);

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_done_res && o_busy_res))
        else $error("done word still shows busy");

    a_abort_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res && (o_status != 2'd0) |-> (o_rd_data == '0))
        else $error("aborted transfer returned nonzero data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 2'd3))
        else $error("undefined status code");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> !o_sda_oe && !o_scl)
        else $error("lines not released while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rd_data) && $stable(o_status))
        else $error("stalled output word changed");

endmodule

bind two_wire_register_master twrm_props u_twrm_props (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_scl      (o_scl),
    .o_sda_oe   (o_sda_oe),
    .o_busy_res (o_busy_res),
    .o_done_res (o_done_res),
    .o_rd_data  (o_rd_data),
    .o_status   (o_status)
);

// ----- bench/twrm_checker.sv -----
`timescale 1ns / 1ps

module twrm_checker
    import twrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_ready,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [ADDR_W-1:0] i_reg_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_sda_in,
    input  logic              o_valid,
    input  logic              i_ready,
    input  logic              o_scl,
    input  logic              o_sda_out,
    input  logic              o_sda_oe,
    input  logic              o_busy_res,
    input  logic              o_done_res,
    input  logic [DATA_W-1:0] o_rd_data,
    input  logic [1:0]        o_status,
    output int                n_errors,
    output int                n_pending
);

    typedef struct packed {
        logic              scl;
        logic              sda_out;
        logic              sda_oe;
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] rd_data;
        t_status           status;
    } t_line_word;

    localparam logic [SHIFT_W-1:0] RX_MASK = SHIFT_W'((1 << RX_BITS) - 1);

    // sequencer state
    t_phase              ph;
    logic [CNT_W-1:0]    bit_cnt;
    logic [SHIFT_W-1:0]  shreg;
    logic                wr_mode;
    logic [DATA_W-1:0]   held_byte;
    logic [DATA_W-1:0]   rd_byte;
    t_status             last_st;
    logic                scl_lvl;
    logic                sda_lvl;
    logic                oe_lvl;

    t_line_word          line_exp_q[$];
    int                  err_cnt = 0;

    task automatic clear_sequencer();
        ph        = PH_IDLE;
        bit_cnt   = '0;
        shreg     = '0;
        wr_mode   = 1'b0;
        held_byte = '0;
        rd_byte   = '0;
        last_st   = ST_OK;
        scl_lvl   = 1'b0;
        sda_lvl   = 1'b0;
        oe_lvl    = 1'b0;
    endtask

    task automatic step_sequencer(
        input  logic [REQ_W-1:0]  req,
        input  logic [ADDR_W-1:0] addr,
        input  logic [DATA_W-1:0] wdat,
        input  logic              sda,
        output t_line_word        res
    );
        logic done;
        done = 1'b0;
        case (ph)
            PH_IDLE: begin
                if (req == REQ_CODE_READ || req == REQ_CODE_WRITE) begin
                    wr_mode   = (req == REQ_CODE_WRITE);
                    held_byte = '0;
                    held_byte[DATA_BITS-1:0] = wdat[DATA_BITS-1:0];
                    shreg     = '0;
                    shreg[FRAME_BITS-1:0] = {addr[ADDR_BITS-1:0], ~wr_mode};
                    oe_lvl    = 1'b1;
                    scl_lvl   = 1'b0;
                    sda_lvl   = 1'b0;
                    ph        = PH_STOP_SCLH;
                end
            end
            PH_STOP_SCLH: begin
                scl_lvl = 1'b1;
                ph      = PH_STOP_SDAH;
            end
            PH_STOP_SDAH: begin
                sda_lvl = 1'b1;
                ph      = PH_START_SDAL;
            end
            PH_START_SDAL: begin
                sda_lvl = 1'b0;
                ph      = PH_START_SCLL;
            end
            PH_START_SCLL: begin
                scl_lvl = 1'b0;
                bit_cnt = CNT_W'(FRAME_BITS);
                ph      = PH_A_SET;
            end
            PH_A_SET: begin
                sda_lvl = shreg[bit_cnt - 1'b1];
                ph      = PH_A_HIGH;
            end
            PH_A_HIGH: begin
                scl_lvl = 1'b1;
                ph      = PH_A_LOW;
            end
            PH_A_LOW: begin
                scl_lvl = 1'b0;
                bit_cnt = bit_cnt - 1'b1;
                ph      = (bit_cnt == 0) ? PH_A_TURN : PH_A_SET;
            end
            PH_A_TURN: begin
                oe_lvl = 1'b0;
                ph     = PH_A_ACKH;
            end
            PH_A_ACKH: begin
                scl_lvl  = 1'b1;
                shreg    = '0;
                shreg[0] = sda;
                ph       = PH_A_ACKL;
            end
            PH_A_ACKL: begin
                scl_lvl = 1'b0;
                if (!shreg[0]) begin
                    rd_byte = '0;
                    last_st = ST_NACK_REG;
                    done    = 1'b1;
                    ph      = PH_IDLE;
                end else if (wr_mode) begin
                    ph = PH_W_TURN;
                end else begin
                    bit_cnt = CNT_W'(RX_BITS);
                    shreg   = '0;
                    ph      = PH_R_HIGH;
                end
            end
            PH_R_HIGH: begin
                scl_lvl = 1'b1;
                shreg   = {shreg[SHIFT_W-2:0], sda} & RX_MASK;
                ph      = PH_R_LOW;
            end
            PH_R_LOW: begin
                scl_lvl = 1'b0;
                bit_cnt = bit_cnt - 1'b1;
                if (bit_cnt == 0) begin
                    rd_byte = '0;
                    if (shreg[0]) begin
                        rd_byte[DATA_BITS-1:0] = shreg[DATA_BITS:1];
                        last_st = ST_OK;
                    end else begin
                        last_st = ST_NACK_DATA;
                    end
                    done = 1'b1;
                    ph   = PH_IDLE;
                end else begin
                    ph = PH_R_HIGH;
                end
            end
            PH_W_TURN: begin
                oe_lvl  = 1'b1;
                shreg   = '0;
                shreg[DATA_BITS-1:0] = held_byte[DATA_BITS-1:0];
                bit_cnt = CNT_W'(DATA_BITS);
                ph      = PH_W_SET;
            end
            PH_W_SET: begin
                sda_lvl = shreg[bit_cnt - 1'b1];
                ph      = PH_W_HIGH;
            end
            PH_W_HIGH: begin
                scl_lvl = 1'b1;
                ph      = PH_W_LOW;
            end
            PH_W_LOW: begin
                scl_lvl = 1'b0;
                bit_cnt = bit_cnt - 1'b1;
                ph      = (bit_cnt == 0) ? PH_W_TURN_IN : PH_W_SET;
            end
            PH_W_TURN_IN: begin
                oe_lvl = 1'b0;
                ph     = PH_W_ACKH;
            end
            PH_W_ACKH: begin
                scl_lvl  = 1'b1;
                shreg    = '0;
                shreg[0] = sda;
                ph       = PH_W_ACKL;
            end
            PH_W_ACKL: begin
                scl_lvl = 1'b0;
                rd_byte = '0;
                last_st = shreg[0] ? ST_OK : ST_NACK_DATA;
                done    = 1'b1;
                ph      = PH_IDLE;
            end
            default: begin
                ph = PH_IDLE;
            end
        endcase
        res.scl     = scl_lvl;
        res.sda_out = sda_lvl;
        res.sda_oe  = oe_lvl;
        res.busy    = (ph != PH_IDLE);
        res.done    = done;
        res.rd_data = rd_byte;
        res.status  = last_st;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_line_word want;
        t_line_word fresh;
        if (!i_rst_n) begin
            clear_sequencer();
            line_exp_q.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (line_exp_q.size() == 0) begin
                    $error("output word with none expected");
                    err_cnt++;
                end else begin
                    want = line_exp_q.pop_front();
                    check_field("scl", 32'(want.scl), 32'(o_scl));
                    check_field("sda_out", 32'(want.sda_out), 32'(o_sda_out));
                    check_field("sda_oe", 32'(want.sda_oe), 32'(o_sda_oe));
                    check_field("busy_res", 32'(want.busy), 32'(o_busy_res));
                    check_field("done_res", 32'(want.done), 32'(o_done_res));
                    check_field("rd_data", 32'(want.rd_data), 32'(o_rd_data));
                    check_field("status", 32'(want.status), 32'(o_status));
                end
            end
            if (i_valid && o_ready) begin
                step_sequencer(i_req_type, i_reg_addr, i_wr_data, i_sda_in, fresh);
                line_exp_q.push_back(fresh);
            end
        end
        n_errors  <= err_cnt;
        n_pending <= line_exp_q.size();
    end

endmodule

// ----- bench/tb_two_wire_register_master.sv -----
`timescale 1ns / 1ps

module tb_two_wire_register_master;
    import twrm_pkg::*;

    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  TICK_TARGET    = 1500;
    localparam logic [REQ_W-1:0] REQ_CODE_TICK  = REQ_TICK;
    localparam logic [REQ_W-1:0] REQ_CODE_SPARE = 2'd3;

    typedef enum logic [1:0] {
        RDY_FULL,
        RDY_MOSTLY,
        RDY_PERIODIC,
        RDY_COIN
    } t_rdy_mode;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdat;
        logic              sda;
    } t_tick_word;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic [REQ_W-1:0]  i_req_type = '0;
    logic [ADDR_W-1:0] i_reg_addr = '0;
    logic [DATA_W-1:0] i_wr_data  = '0;
    logic              i_sda_in   = 1'b0;
    logic              i_ready    = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_scl;
    logic              o_sda_out;
    logic              o_sda_oe;
    logic              o_busy_res;
    logic              o_done_res;
    logic [DATA_W-1:0] o_rd_data;
    logic [1:0]        o_status;
    int                n_errors;
    int                n_pending;

    t_tick_word        tick_q[$];
    t_tick_word        cur;
    int                burst_left  = 1;
    int                gap_left    = 0;
    t_rdy_mode         rdy_mode    = RDY_FULL;
    int                rdy_left    = 0;
    logic [1:0]        rdy_phase   = '0;
    int                idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    two_wire_register_master dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_reg_addr (i_reg_addr),
        .i_wr_data  (i_wr_data),
        .i_sda_in   (i_sda_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_scl      (o_scl),
        .o_sda_out  (o_sda_out),
        .o_sda_oe   (o_sda_oe),
        .o_busy_res (o_busy_res),
        .o_done_res (o_done_res),
        .o_rd_data  (o_rd_data),
        .o_status   (o_status)
    );

    twrm_checker u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_reg_addr (i_reg_addr),
        .i_wr_data  (i_wr_data),
        .i_sda_in   (i_sda_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_scl      (o_scl),
        .o_sda_out  (o_sda_out),
        .o_sda_oe   (o_sda_oe),
        .o_busy_res (o_busy_res),
        .o_done_res (o_done_res),
        .o_rd_data  (o_rd_data),
        .o_status   (o_status),
        .n_errors   (n_errors),
        .n_pending  (n_pending)
    );

    task automatic push_tick(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdat, input logic sda);
        t_tick_word w;
        w.req  = req;
        w.addr = addr;
        w.wdat = wdat;
        w.sda  = sda;
        tick_q.push_back(w);
    endtask

    // One request word plus the ticks of its line sequence. Partner levels
    // land on the ticks where SCL rises: register ack at 21, read bits at
    // 23 + 2j with the trailing ack at 39, write ack at 49.
    task automatic add_transfer(input bit wr, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data,
                                input logic [DATA_W-1:0] rx_byte,
                                input bit reg_ack, input bit data_ack, input int cut_at);
        bit sda_plan[51];
        int len;
        len = wr ? 51 : 41;
        if (cut_at > 0 && cut_at < len) len = cut_at;
        foreach (sda_plan[k]) sda_plan[k] = 1'($urandom_range(0, 1));
        sda_plan[21] = reg_ack;
        if (wr) begin
            sda_plan[49] = data_ack;
        end else begin
            for (int j = 0; j < DATA_BITS; j++) sda_plan[23 + 2 * j] = rx_byte[DATA_BITS-1-j];
            sda_plan[39] = data_ack;
        end
        push_tick(wr ? REQ_CODE_WRITE : REQ_CODE_READ, addr, data, sda_plan[0]);
        for (int k = 1; k < len; k++) begin
            // stray requests while busy must be ignored
            if ($urandom_range(0, 7) == 0)
                push_tick(REQ_W'($urandom_range(0, 3)), ADDR_W'($urandom),
                          DATA_W'($urandom), sda_plan[k]);
            else
                push_tick(REQ_CODE_TICK, ADDR_W'($urandom), DATA_W'($urandom), sda_plan[k]);
        end
    endtask

    initial begin
        push_tick(REQ_CODE_TICK, '0, '0, 1'b0);
        push_tick(REQ_CODE_TICK, '1, '1, 1'b1);
        push_tick(REQ_CODE_SPARE, '1, '1, 1'b1);
        push_tick(REQ_CODE_SPARE, '0, '0, 1'b0);
        add_transfer(1'b0, '0, '0, 8'hFF, 1'b1, 1'b1, 0);
        add_transfer(1'b1, '1, 8'h00, '0, 1'b1, 1'b1, 0);
        add_transfer(1'b0, '1, '1, 8'hA5, 1'b0, 1'b1, 0);
        add_transfer(1'b1, 4'h5, 8'h3C, '0, 1'b1, 1'b0, 0);
        add_transfer(1'b0, 4'hA, '0, 8'h5A, 1'b1, 1'b0, 0);
        add_transfer(1'b1, '0, 8'hFF, '0, 1'b0, 1'b1, 0);
        add_transfer(1'b0, 4'h3, '0, 8'h00, 1'b1, 1'b1, 0);
        while (tick_q.size() < TICK_TARGET) begin
            if ($urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(1, 10))
                    push_tick(REQ_W'($urandom_range(0, 3)), ADDR_W'($urandom),
                              DATA_W'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                add_transfer(1'($urandom_range(0, 1)), ADDR_W'($urandom),
                             DATA_W'($urandom), DATA_W'($urandom),
                             $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
                             ($urandom_range(0, 15) == 0) ? $urandom_range(1, 50) : 0);
                repeat ($urandom_range(0, 3))
                    push_tick(REQ_CODE_TICK, ADDR_W'($urandom), DATA_W'($urandom),
                              1'($urandom_range(0, 1)));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        @(negedge i_clk);
        while (tick_q.size() != 0 || i_valid || n_pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("PASS two_wire_register_master");
        end else begin
            $display("FAIL two_wire_register_master");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (tick_q.size() > 0) begin
                cur = tick_q.pop_front();
                i_valid    <= 1'b1;
                i_req_type <= cur.req;
                i_reg_addr <= cur.addr;
                i_wr_data  <= cur.wdat;
                i_sda_in   <= cur.sda;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode <= t_rdy_mode'($urandom_range(0, 3));
            rdy_left <= $urandom_range(16, 200);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        rdy_phase <= rdy_phase + 1'b1;
        case (rdy_mode)
            RDY_FULL:     i_ready <= 1'b1;
            RDY_MOSTLY:   i_ready <= ($urandom_range(0, 3) != 0);
            RDY_PERIODIC: i_ready <= (rdy_phase == 2'd0);
            default:      i_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL two_wire_register_master");
            $finish;
        end
    end

endmodule
